@@ design/pcip_pkg.sv @@
package pcip_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int ESTIMATE_W  = 64;
    localparam int PROD_W      = 48;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ACC   = 1'b1;

    // one classified transaction as it waits between front and back
    typedef struct packed {
        logic        is_acc;
        logic [7:0]  addr;      // table index for a load, masked delta otherwise
        logic [15:0] value;
        logic [15:0] lhs_radius;
        logic [15:0] rhs_radius;
        logic        last;
    } t_q_item;

endpackage

@@ design/polar_code_inner_product.sv @@
// Polar-coded inner product estimator.
// Input channel (i_in_valid / o_in_stall) carries one transaction per item:
// a load writes one cosine table entry, an accumulate adds
// lhs_radius * rhs_radius * cos[(lhs_angle - rhs_angle) & mask] to the sum.
// The accumulate marked last_pair emits the saturated sum on the output
// channel (o_out_valid / i_out_stall) as o_estimate and clears the sum.
// i_cfg_we / i_cfg_wdata write the angle delta mask; write only while idle.
// Throughput: one transaction per cycle while not stalled. The front
// classifies and pushes into a four-entry queue; the back runs table read,
// radius product, cosine product and saturating add as a three-stage pipeline
// behind it, whose last register holds o_estimate.
// While a result waits and i_out_stall is high the back end holds; the
// queue keeps taking transactions until full, then o_in_stall rises.
// Reset (i_rst_n low, synchronous) empties the queue, clears the sum and sets
// the mask to all ones. Table entries are undefined until loaded.
module polar_code_inner_product #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic [7:0]         i_table_index,
    input  logic signed [15:0] i_table_value,
    input  logic [15:0]        i_lhs_radius,
    input  logic [15:0]        i_rhs_radius,
    input  logic [7:0]         i_lhs_angle,
    input  logic [7:0]         i_rhs_angle,
    input  logic               i_last_pair,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_estimate
);
    import pcip_pkg::*;

    t_q_item push_item;
    t_q_item pop_item;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;

    pcip_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_lhs_radius  (i_lhs_radius),
        .i_rhs_radius  (i_rhs_radius),
        .i_lhs_angle   (i_lhs_angle),
        .i_rhs_angle   (i_rhs_angle),
        .i_last_pair   (i_last_pair),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_item      (push_item)
    );

    pcip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (pop_item)
    );

    pcip_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_item    (pop_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_estimate  (o_estimate)
    );

endmodule

@@ design/pcip_front.sv @@
module pcip_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic [7:0]         i_table_index,
    input  logic signed [15:0] i_table_value,
    input  logic [15:0]        i_lhs_radius,
    input  logic [15:0]        i_rhs_radius,
    input  logic [7:0]         i_lhs_angle,
    input  logic [7:0]         i_rhs_angle,
    input  logic               i_last_pair,
    input  logic               i_q_full,
    output logic               o_q_push,
    output pcip_pkg::t_q_item  o_q_item
);
    import pcip_pkg::*;

    logic [7:0] r_mask;
    logic [7:0] delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 8'hFF;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    // difference wraps modulo 256 by width
    assign delta = (i_lhs_angle - i_rhs_angle) & r_mask;

    always_comb begin
        o_q_item.is_acc     = (i_command == CMD_ACC);
        o_q_item.addr       = (i_command == CMD_ACC) ? delta : i_table_index;
        o_q_item.value      = i_table_value;
        o_q_item.lhs_radius = i_lhs_radius;
        o_q_item.rhs_radius = i_rhs_radius;
        o_q_item.last       = (i_command == CMD_ACC) && i_last_pair;
    end

    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

endmodule

@@ design/pcip_queue.sv @@
module pcip_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pcip_pkg::t_q_item i_item,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output pcip_pkg::t_q_item o_item
);
    import pcip_pkg::*;

    t_q_item            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_count == QCNT_W'(QUEUE_DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue read while empty");

endmodule

@@ design/pcip_back.sv @@
module pcip_back #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  pcip_pkg::t_q_item  i_q_item,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_estimate
);
    import pcip_pkg::*;

    localparam int TIDX_W = $clog2(TABLE_ENTRIES);

    logic signed [15:0]         r_table [TABLE_ENTRIES];

    logic                       r_s1_valid;
    logic                       r_s1_last;
    logic                       r_s1_ok;
    logic [31:0]                r_s1_rr;
    logic signed [15:0]         r_s1_cos;

    logic                       r_s2_valid;
    logic                       r_s2_last;
    logic signed [PROD_W-1:0]   r_s2_prod;

    logic signed [ESTIMATE_W-1:0] r_acc;
    logic                       r_out_valid;
    logic signed [ESTIMATE_W-1:0] r_out_data;

    logic                       adv;
    logic                       pop;
    logic                       addr_ok;
    logic [TIDX_W-1:0]          tidx;
    logic signed [32:0]         rr_s;
    logic signed [15:0]         cos_sel;
    logic signed [48:0]         mul;
    logic [ESTIMATE_W:0]        sum_x;
    logic [ESTIMATE_W-1:0]      sum_sat;

    // whole back end holds only while a result waits and the receiver stalls
    assign adv     = !(r_out_valid && i_out_stall);
    assign pop     = adv && !i_q_empty;
    assign o_q_pop = pop;

    assign addr_ok = ({1'b0, i_q_item.addr} < 9'(TABLE_ENTRIES));
    assign tidx    = i_q_item.addr[TIDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (pop && !i_q_item.is_acc && addr_ok) begin
            r_table[tidx] <= i_q_item.value;
        end
        if (pop && i_q_item.is_acc) begin
            r_s1_cos <= r_table[tidx];
        end
    end

    assign rr_s    = $signed({1'b0, r_s1_rr});
    assign cos_sel = r_s1_ok ? r_s1_cos : 16'sd0;
    assign mul     = 49'(rr_s) * 49'(cos_sel);

    // product magnitude stays below 2^47, so 48 bits hold it exactly
    assign sum_x = {r_acc[ESTIMATE_W-1], r_acc}
                 + {{(ESTIMATE_W + 1 - PROD_W){r_s2_prod[PROD_W-1]}}, r_s2_prod};

    always_comb begin
        if (sum_x[ESTIMATE_W] != sum_x[ESTIMATE_W-1]) begin
            sum_sat = sum_x[ESTIMATE_W] ? {1'b1, {(ESTIMATE_W-1){1'b0}}}
                                        : {1'b0, {(ESTIMATE_W-1){1'b1}}};
        end else begin
            sum_sat = sum_x[ESTIMATE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_last <= i_q_item.last;
            r_s1_ok   <= addr_ok;
            r_s1_rr   <= 32'(i_q_item.lhs_radius) * 32'(i_q_item.rhs_radius);
            r_s2_last <= r_s1_last;
            r_s2_prod <= mul[PROD_W-1:0];
        end
        if (adv && r_s2_valid && r_s2_last) begin
            r_out_data <= sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_valid <= pop && i_q_item.is_acc;
                r_s2_valid <= r_s1_valid;
                if (r_s2_valid) begin
                    r_acc <= r_s2_last ? '0 : sum_sat;
                end
            end
            if (adv && r_s2_valid && r_s2_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_estimate  = r_out_data;

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s2_valid && r_s2_last) |=> (r_acc == '0 && r_out_valid))
        else $error("sum not emitted and cleared on last pair");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_acc) && $stable(r_s2_prod))
        else $error("pipeline moved while output held");

    a_no_pop_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !(r_out_valid && i_out_stall))
        else $error("queue popped while back end held");

endmodule
